[rtl/fpmm_pkg.sv]
// Package for the fixed-point matrix multiply block: widths, codes and request/result types.
`default_nettype none

package fpmm_pkg;

    // Element format is signed Q8.8.
    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int MAX_DIM_DEF = 16;

    // Index and register field widths are fixed by the request format.
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 5;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(16);

    typedef enum logic [1:0] {
        KIND_WRITE_A = 2'd0,
        KIND_WRITE_B = 2'd1,
        KIND_PRODUCT = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_ROW_COUNT    = 2'd0,
        REG_INNER_LENGTH = 2'd1,
        REG_COL_COUNT    = 2'd2,
        REG_NONE         = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_DRAIN = 2'd2
    } state_t;

    typedef struct packed {
        kind_t                         kind;
        logic [IDX_W-1:0]              row_index;
        logic [IDX_W-1:0]              col_index;
        logic signed [DATA_WIDTH-1:0]  element_value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  product_value;
        logic                          saturated;
        logic                          index_error;
    } result_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic data_valid;
    } mac_ctrl_t;

    // Status from the multiply-accumulate unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic saturated;
    } mac_stat_t;

endpackage

`default_nettype wire

[rtl/fpmm_store.sv]
// Single-port-write, single-port-read synchronous memory for one operand matrix.
`default_nettype none

module fpmm_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int WIDTH  = 16
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/fpmm_mac.sv]
// Multiply-accumulate unit with the final floor shift and saturation.
`default_nettype none

module fpmm_mac #(
    parameter int MAX_DIM = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire fpmm_pkg::mac_ctrl_t               ctrl,
    input  wire logic [fpmm_pkg::DATA_WIDTH-1:0]   a_data,
    input  wire logic [fpmm_pkg::DATA_WIDTH-1:0]   b_data,
    output      fpmm_pkg::mac_stat_t               stat,
    output      logic [fpmm_pkg::DATA_WIDTH-1:0]   value
);

    import fpmm_pkg::*;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int TW     = (ACC_W > 64) ? 64 : ACC_W;
    localparam logic signed [TW-1:0] SAT_TOP =
        TW'((longint'(1) <<< (DATA_WIDTH - 1)) - longint'(1));
    localparam logic signed [TW-1:0] SAT_BOT = -SAT_TOP - TW'(1);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [TW-1:0]     trunc;
    logic                     over_top;
    logic                     under_bot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.data_valid)
        begin
            prod_reg <= signed'(a_data) * signed'(b_data);
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Floor shift, then clip to the element range.
    always_comb
    begin
        shifted   = acc_reg >>> FRAC_BITS;
        trunc     = signed'(shifted[TW-1:0]);
        over_top  = trunc > SAT_TOP;
        under_bot = trunc < SAT_BOT;
        if (over_top)
        begin
            value = SAT_TOP[DATA_WIDTH-1:0];
        end
        else if (under_bot)
        begin
            value = SAT_BOT[DATA_WIDTH-1:0];
        end
        else
        begin
            value = trunc[DATA_WIDTH-1:0];
        end
        stat.busy      = prod_vld_reg;
        stat.saturated = over_top | under_bot;
    end

endmodule

`default_nettype wire

[rtl/fixed_point_matrix_multiply_top.sv]
// Top level of the fixed-point matrix multiply block: configuration, sequencer and stores.
// A write request (or any request with an index error, or the unused kind) has its result
// in the output register in the cycle after it is accepted.
// A product request streams one operand pair per cycle from the two stores into one
// multiply-accumulate unit, one request at a time.
// Reset (rst_n, asynchronous, active low) sets all three sizes to 16 and empties the output
// register; the operand stores are not cleared and hold undefined data until written.
`default_nettype none

module fixed_point_matrix_multiply_top #(
    parameter int MAX_DIM = fpmm_pkg::MAX_DIM_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Request channel.
    input  wire logic                          item_valid,
    output      logic                          item_stall,
    input  wire fpmm_pkg::item_t               item,
    // Result channel.
    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output      fpmm_pkg::result_t             result,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpmm_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fpmm_pkg::PDATA_W-1:0]  pwdata,
    output      logic [fpmm_pkg::PDATA_W-1:0]  prdata,
    output      logic                          pready
);

    import fpmm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);

    // ------------------------------------------------------------------
    // Configuration registers. The size in effect saturates at MAX_DIM.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] inner_reg;
    logic [CFG_W-1:0] cols_reg;
    logic             cfg_write;
    reg_idx_t         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= SIZE_RESET;
            inner_reg <= SIZE_RESET;
            cols_reg  <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ROW_COUNT:    rows_reg  <= pwdata[CFG_W-1:0];
                REG_INNER_LENGTH: inner_reg <= pwdata[CFG_W-1:0];
                REG_COL_COUNT:    cols_reg  <= pwdata[CFG_W-1:0];
                REG_NONE:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROW_COUNT:    prdata = PDATA_W'(rows_reg);
            REG_INNER_LENGTH: prdata = PDATA_W'(inner_reg);
            REG_COL_COUNT:    prdata = PDATA_W'(cols_reg);
            REG_NONE:         prdata = '0;
        endcase
    end

    logic [DIM_W-1:0] rows_eff;
    logic [DIM_W-1:0] inner_eff;
    logic [DIM_W-1:0] cols_eff;

    assign rows_eff  = (32'(rows_reg)  > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_reg);
    assign inner_eff = (32'(inner_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(inner_reg);
    assign cols_eff  = (32'(cols_reg)  > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_reg);

    // ------------------------------------------------------------------
    // Request decode and range checks.
    // ------------------------------------------------------------------
    logic row_in_rows;
    logic row_in_inner;
    logic col_in_inner;
    logic col_in_cols;
    logic idx_error;
    logic is_request;

    assign row_in_rows  = 32'(item.row_index) < 32'(rows_eff);
    assign row_in_inner = 32'(item.row_index) < 32'(inner_eff);
    assign col_in_inner = 32'(item.col_index) < 32'(inner_eff);
    assign col_in_cols  = 32'(item.col_index) < 32'(cols_eff);
    assign is_request   = (item.kind == KIND_PRODUCT);

    always_comb
    begin
        unique case (item.kind)
            KIND_WRITE_A: idx_error = !(row_in_rows && col_in_inner);
            KIND_WRITE_B: idx_error = !(row_in_inner && col_in_cols);
            KIND_PRODUCT: idx_error = !(row_in_rows && col_in_cols);
            KIND_UNUSED:  idx_error = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer. A product request walks k from 0 to inner_length - 1, reading
    // A at row*MAX_DIM+k and B at k*MAX_DIM+col, one pair per cycle. The
    // accumulate pipeline is two stages deep, so the drain state waits for it
    // to empty before the result is latched. Requests that finish at once
    // need a free output register; a product request may be taken while the
    // previous result still waits.
    // ------------------------------------------------------------------
    state_t            state_reg;
    state_t            state_next;
    logic [DIM_W-1:0]  k_reg;
    logic [DIM_W-1:0]  k_next;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [ADDR_W-1:0] a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg;
    logic [ADDR_W-1:0] b_addr_next;
    logic              rd_vld_reg;
    logic              rd_vld_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    result_t           result_reg;
    result_t           result_next;

    logic              slot_free;
    logic              accept;
    logic              start;
    logic              issue;
    logic              a_wr_en;
    logic              b_wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [DATA_WIDTH-1:0] a_rd_data;
    logic [DATA_WIDTH-1:0] b_rd_data;
    logic [DATA_WIDTH-1:0] mac_value;
    mac_ctrl_t             mac_ctrl;
    mac_stat_t             mac_stat;

    assign slot_free  = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != ST_IDLE) || (!slot_free && !(is_request && !idx_error));
    assign accept     = item_valid && !item_stall;
    assign wr_addr    = ADDR_W'(32'(item.row_index) * MAX_DIM + 32'(item.col_index));

    always_comb
    begin
        state_next        = state_reg;
        k_next            = k_reg;
        a_addr_next       = a_addr_reg;
        b_addr_next       = b_addr_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        start             = 1'b0;
        issue             = 1'b0;
        a_wr_en           = 1'b0;
        b_wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_request && !idx_error)
                    begin
                        start       = 1'b1;
                        k_next      = '0;
                        a_addr_next = ADDR_W'(32'(item.row_index) * MAX_DIM);
                        b_addr_next = ADDR_W'(item.col_index);
                        state_next  = ST_RUN;
                    end
                    else
                    begin
                        a_wr_en = (item.kind == KIND_WRITE_A) && !idx_error;
                        b_wr_en = (item.kind == KIND_WRITE_B) && !idx_error;
                        result_next.product_value = '0;
                        result_next.saturated     = 1'b0;
                        result_next.index_error   = idx_error;
                        result_valid_next         = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (k_reg == inner_eff)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    issue       = 1'b1;
                    k_next      = k_reg + DIM_W'(1);
                    a_addr_next = a_addr_reg + ADDR_W'(1);
                    b_addr_next = b_addr_reg + ADDR_W'(MAX_DIM);
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mac_stat.busy && slot_free)
                begin
                    result_next.product_value = signed'(mac_value);
                    result_next.saturated     = mac_stat.saturated;
                    result_next.index_error   = 1'b0;
                    result_valid_next         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_vld_next = issue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_vld_reg       <= rd_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Operand stores and the multiply-accumulate unit.
    // ------------------------------------------------------------------
    fpmm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .WIDTH  (DATA_WIDTH)
    ) u_left_store (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.element_value),
        .rd_en   (issue),
        .rd_addr (a_addr_reg),
        .rd_data (a_rd_data)
    );

    fpmm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .WIDTH  (DATA_WIDTH)
    ) u_right_store (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.element_value),
        .rd_en   (issue),
        .rd_addr (b_addr_reg),
        .rd_data (b_rd_data)
    );

    assign mac_ctrl.clear      = start;
    assign mac_ctrl.data_valid = rd_vld_reg;

    fpmm_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (a_rd_data),
        .b_data (b_rd_data),
        .stat   (mac_stat),
        .value  (mac_value)
    );

endmodule

`default_nettype wire

[rtl/fpmm_checker.sv]
// Port-level checker for the fixed-point matrix multiply block, bound to the top level.
`default_nettype none

module fpmm_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire fpmm_pkg::item_t    item,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire fpmm_pkg::result_t  result
);

    import fpmm_pkg::*;

    localparam logic signed [DATA_WIDTH-1:0] ELEM_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] ELEM_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or was dropped");

    // Anything other than a product request answers on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.kind != KIND_PRODUCT) |=> result_valid)
        else $error("write or unused request gave no result on the next cycle");

    // An index error carries no product and no saturation flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.index_error |->
            (result.product_value == '0) && !result.saturated)
        else $error("index error result carries data");

    // A saturated result sits at one end of the element range.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.product_value == ELEM_MAX) || (result.product_value == ELEM_MIN))
        else $error("saturated result not at a range limit");

endmodule

bind fixed_point_matrix_multiply_top fpmm_checker u_fpmm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
